// ===== src/csvt_pkg.sv =====
// Types and constants shared by the CSV byte tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

    // Special characters
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;

    // field_end codes
    localparam logic [1:0] FEND_NONE     = 2'd0;
    localparam logic [1:0] FEND_UNQUOTED = 2'd1;
    localparam logic [1:0] FEND_QUOTED   = 2'd2;

    // delimiter codes
    localparam logic [1:0] DELIM_NONE   = 2'd0;
    localparam logic [1:0] DELIM_COMMA  = 2'd1;
    localparam logic [1:0] DELIM_RECORD = 2'd2;
    localparam logic [1:0] DELIM_EOI    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_QUOTE_IN_FLD = 2'd1;
    localparam logic [1:0] ERR_OPEN_QUOTE   = 2'd2;

    // Scan mode between bytes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FIELD  = 2'd1,
        MODE_QFIELD = 2'd2,
        MODE_QSEEN  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] content_byte;
        logic       content_valid;
        logic       field_start;
        logic [1:0] field_end;
        logic [1:0] delimiter;
        logic [1:0] error_code;
    } out_item_t;

endpackage

// ===== src/csv_byte_tokenizer_unit.sv =====
// Top level of the CSV byte tokenizer: mode logic and result register.
`timescale 1ns / 1ps

// CSV byte tokenizer. Takes one text byte (or an end-of-text mark) per
// transfer and returns exactly one result per transfer: content byte, field
// start/end marks, delimiter and error code. Throughput is one item per
// clock unless the output stalls; the result is written into the output
// register when the input transfer is taken. The only stall comes from the
// single output register: in_ready is low while a result waits and
// out_ready is low. Once an error is detected the block repeats that error
// code for every later item until rst_n is asserted.
module csv_byte_tokenizer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csvt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output csvt_pkg::out_item_t out_data
);

    csvt_pkg::mode_t     mode_reg;
    csvt_pkg::mode_t     mode_next;
    logic [1:0]          halted_reg;
    logic [1:0]          halted_next;
    logic                out_valid_reg;
    csvt_pkg::out_item_t out_reg;
    csvt_pkg::out_item_t out_next;

    logic       accept;
    logic [7:0] b;
    logic       eot;
    logic       is_comma;
    logic       is_nl;
    logic       is_quote;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign b        = in_data.in_byte;
    assign eot      = in_data.end_of_text;
    assign is_comma = (b == csvt_pkg::CH_COMMA);
    assign is_nl    = (b == csvt_pkg::CH_NEWLINE);
    assign is_quote = (b == csvt_pkg::CH_QUOTE);

    // Next mode and latched error
    always_comb
    begin
        mode_next   = mode_reg;
        halted_next = halted_reg;
        if (halted_reg != csvt_pkg::ERR_NONE)
        begin
            mode_next = mode_reg;
        end
        else if (eot)
        begin
            if (mode_reg == csvt_pkg::MODE_QFIELD)
                halted_next = csvt_pkg::ERR_OPEN_QUOTE;
            else
                mode_next = csvt_pkg::MODE_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                csvt_pkg::MODE_FIELD:
                begin
                    if (is_quote)
                        halted_next = csvt_pkg::ERR_QUOTE_IN_FLD;
                    else if (is_comma || is_nl)
                        mode_next = csvt_pkg::MODE_IDLE;
                end
                csvt_pkg::MODE_QFIELD:
                begin
                    if (is_quote)
                        mode_next = csvt_pkg::MODE_QSEEN;
                end
                csvt_pkg::MODE_QSEEN:
                begin
                    // doubled quote stays in the field; else dispatch as idle
                    if (is_quote)
                        mode_next = csvt_pkg::MODE_QFIELD;
                    else if (is_comma || is_nl)
                        mode_next = csvt_pkg::MODE_IDLE;
                    else
                        mode_next = csvt_pkg::MODE_FIELD;
                end
                csvt_pkg::MODE_IDLE:
                begin
                    if (is_comma || is_nl)
                        mode_next = csvt_pkg::MODE_IDLE;
                    else if (is_quote)
                        mode_next = csvt_pkg::MODE_QFIELD;
                    else
                        mode_next = csvt_pkg::MODE_FIELD;
                end
                default:
                    mode_next = csvt_pkg::MODE_IDLE;
            endcase
        end
    end

    // Result for the current item
    always_comb
    begin
        out_next = '0;
        if (halted_reg != csvt_pkg::ERR_NONE)
        begin
            out_next.error_code = halted_reg;
        end
        else if (eot)
        begin
            if (mode_reg == csvt_pkg::MODE_QFIELD)
            begin
                out_next.error_code = csvt_pkg::ERR_OPEN_QUOTE;
            end
            else
            begin
                if (mode_reg == csvt_pkg::MODE_FIELD)
                    out_next.field_end = csvt_pkg::FEND_UNQUOTED;
                else if (mode_reg == csvt_pkg::MODE_QSEEN)
                    out_next.field_end = csvt_pkg::FEND_QUOTED;
                out_next.delimiter = csvt_pkg::DELIM_EOI;
            end
        end
        else
        begin
            unique case (mode_reg)
                csvt_pkg::MODE_FIELD:
                begin
                    if (is_quote)
                    begin
                        out_next.error_code = csvt_pkg::ERR_QUOTE_IN_FLD;
                    end
                    else if (is_comma)
                    begin
                        out_next.field_end = csvt_pkg::FEND_UNQUOTED;
                        out_next.delimiter = csvt_pkg::DELIM_COMMA;
                    end
                    else if (is_nl)
                    begin
                        out_next.field_end = csvt_pkg::FEND_UNQUOTED;
                        out_next.delimiter = csvt_pkg::DELIM_RECORD;
                    end
                    else
                    begin
                        out_next.content_byte  = b;
                        out_next.content_valid = 1'b1;
                    end
                end
                csvt_pkg::MODE_QFIELD:
                begin
                    if (!is_quote)
                    begin
                        out_next.content_byte  = b;
                        out_next.content_valid = 1'b1;
                    end
                end
                csvt_pkg::MODE_QSEEN:
                begin
                    if (is_quote)
                    begin
                        out_next.content_byte  = csvt_pkg::CH_QUOTE;
                        out_next.content_valid = 1'b1;
                    end
                    else
                    begin
                        out_next.field_end = csvt_pkg::FEND_QUOTED;
                        if (is_comma)
                            out_next.delimiter = csvt_pkg::DELIM_COMMA;
                        else if (is_nl)
                            out_next.delimiter = csvt_pkg::DELIM_RECORD;
                        else
                        begin
                            out_next.content_byte  = b;
                            out_next.content_valid = 1'b1;
                            out_next.field_start   = 1'b1;
                        end
                    end
                end
                csvt_pkg::MODE_IDLE:
                begin
                    if (is_comma)
                        out_next.delimiter = csvt_pkg::DELIM_COMMA;
                    else if (is_nl)
                        out_next.delimiter = csvt_pkg::DELIM_RECORD;
                    else if (is_quote)
                        out_next.field_start = 1'b1;
                    else
                    begin
                        out_next.content_byte  = b;
                        out_next.content_valid = 1'b1;
                        out_next.field_start   = 1'b1;
                    end
                end
                default:
                    out_next = '0;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= csvt_pkg::MODE_IDLE;
            halted_reg    <= csvt_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                halted_reg <= halted_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    // Once halted, the latched error never changes
    assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg != csvt_pkg::ERR_NONE) |=> (halted_reg == $past(halted_reg)))
        else $error("latched error changed while halted");

    // An item taken while halted answers with the latched code
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && halted_reg != csvt_pkg::ERR_NONE)
        |=> (out_valid && out_data.error_code == $past(halted_reg)))
        else $error("halted result does not repeat the error code");

    // An error result carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error_code != csvt_pkg::ERR_NONE)
        |-> (!out_data.content_valid && !out_data.field_start
             && out_data.field_end == csvt_pkg::FEND_NONE
             && out_data.delimiter == csvt_pkg::DELIM_NONE))
        else $error("error result has other fields set");

    // Content and a delimiter never come in the same result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.content_valid)
        |-> (out_data.delimiter == csvt_pkg::DELIM_NONE))
        else $error("content byte together with a delimiter");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the CSV byte tokenizer unit.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TEXT_ITEMS  = 1400;
    localparam int unsigned LONG_HOLD   = 80;
    localparam int unsigned DIR_ROWS    = 24;

    // Tokenizer state as the checker tracks it
    typedef struct packed {
        csvt_pkg::mode_t mode;
        logic [1:0]      halt;
    } scan_state_t;

    // One stimulus row; want is used only when typed is set
    typedef struct {
        csvt_pkg::in_item_t  item;
        bit                  typed;
        csvt_pkg::out_item_t want;
    } text_entry_t;

    // One directed row: byte, end-of-text mark, typed flag, typed result
    typedef struct packed {
        logic [7:0]          in_byte;
        logic                eot;
        logic                typed;
        csvt_pkg::out_item_t want;
    } dir_row_t;

    // Directed rows: extremes, delimiters, doubled quote, byte after
    // closing quote, carriage return as content, end of text in idle, field and quote-seen modes
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_NONE,
                               csvt_pkg::DELIM_EOI, csvt_pkg::ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, csvt_pkg::FEND_NONE,
                               csvt_pkg::DELIM_NONE, csvt_pkg::ERR_NONE}},
        '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, csvt_pkg::FEND_NONE,
                               csvt_pkg::DELIM_NONE, csvt_pkg::ERR_NONE}},
        '{csvt_pkg::CH_COMMA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_UNQUOTED,
                                            csvt_pkg::DELIM_COMMA, csvt_pkg::ERR_NONE}},
        '{csvt_pkg::CH_COMMA, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_NONE,
                                            csvt_pkg::DELIM_COMMA, csvt_pkg::ERR_NONE}},
        '{csvt_pkg::CH_NEWLINE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_NONE,
                                              csvt_pkg::DELIM_RECORD, csvt_pkg::ERR_NONE}},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, csvt_pkg::FEND_NONE,
                                            csvt_pkg::DELIM_NONE, csvt_pkg::ERR_NONE}},
        '{csvt_pkg::CH_COMMA, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_NEWLINE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h0D, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_COMMA, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_NEWLINE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b0, 1'b0, '0},
        '{csvt_pkg::CH_QUOTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_QUOTED,
                                            csvt_pkg::DELIM_EOI, csvt_pkg::ERR_NONE}},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, csvt_pkg::FEND_UNQUOTED,
                               csvt_pkg::DELIM_EOI, csvt_pkg::ERR_NONE}}
    };

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    csvt_pkg::in_item_t  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    csvt_pkg::out_item_t out_data;

    text_entry_t         text_q[$];
    csvt_pkg::out_item_t expected_tokens[$];
    scan_state_t         gen_scan;
    scan_state_t         track_scan;
    bit                  failed;
    int unsigned         cycles;
    int unsigned         tokens_seen;

    csv_byte_tokenizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // A byte seen between tokens: delimiter, quoted open or unquoted open
    function automatic void open_token(inout scan_state_t st,
                                       inout csvt_pkg::out_item_t r,
                                       input logic [7:0] b);
        if (b == csvt_pkg::CH_COMMA)
        begin
            r.delimiter = csvt_pkg::DELIM_COMMA;
            st.mode = csvt_pkg::MODE_IDLE;
        end
        else if (b == csvt_pkg::CH_NEWLINE)
        begin
            r.delimiter = csvt_pkg::DELIM_RECORD;
            st.mode = csvt_pkg::MODE_IDLE;
        end
        else if (b == csvt_pkg::CH_QUOTE)
        begin
            r.field_start = 1'b1;
            st.mode = csvt_pkg::MODE_QFIELD;
        end
        else
        begin
            r.content_byte = b;
            r.content_valid = 1'b1;
            r.field_start = 1'b1;
            st.mode = csvt_pkg::MODE_FIELD;
        end
    endfunction

    // Next result of the tokenizer for one input transfer
    function automatic csvt_pkg::out_item_t tokenize_byte(inout scan_state_t st,
                                                          input csvt_pkg::in_item_t it);
        csvt_pkg::out_item_t r;
        logic [1:0]          err;
        r = '0;
        err = csvt_pkg::ERR_NONE;
        if (st.halt != csvt_pkg::ERR_NONE)
            r.error_code = st.halt;
        else if (it.end_of_text)
        begin
            if (st.mode == csvt_pkg::MODE_QFIELD)
                err = csvt_pkg::ERR_OPEN_QUOTE;
            else
            begin
                if (st.mode == csvt_pkg::MODE_FIELD)
                    r.field_end = csvt_pkg::FEND_UNQUOTED;
                else if (st.mode == csvt_pkg::MODE_QSEEN)
                    r.field_end = csvt_pkg::FEND_QUOTED;
                r.delimiter = csvt_pkg::DELIM_EOI;
                st.mode = csvt_pkg::MODE_IDLE;
            end
        end
        else
        begin
            case (st.mode)
                csvt_pkg::MODE_FIELD:
                begin
                    if (it.in_byte == csvt_pkg::CH_QUOTE)
                        err = csvt_pkg::ERR_QUOTE_IN_FLD;
                    else if (it.in_byte == csvt_pkg::CH_COMMA
                             || it.in_byte == csvt_pkg::CH_NEWLINE)
                    begin
                        r.field_end = csvt_pkg::FEND_UNQUOTED;
                        r.delimiter = (it.in_byte == csvt_pkg::CH_COMMA)
                                      ? csvt_pkg::DELIM_COMMA : csvt_pkg::DELIM_RECORD;
                        st.mode = csvt_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        r.content_byte = it.in_byte;
                        r.content_valid = 1'b1;
                    end
                end
                csvt_pkg::MODE_QFIELD:
                begin
                    if (it.in_byte == csvt_pkg::CH_QUOTE)
                        st.mode = csvt_pkg::MODE_QSEEN;
                    else
                    begin
                        r.content_byte = it.in_byte;
                        r.content_valid = 1'b1;
                    end
                end
                csvt_pkg::MODE_QSEEN:
                begin
                    // doubled quote stays in the field, anything else closes it
                    if (it.in_byte == csvt_pkg::CH_QUOTE)
                    begin
                        r.content_byte = csvt_pkg::CH_QUOTE;
                        r.content_valid = 1'b1;
                        st.mode = csvt_pkg::MODE_QFIELD;
                    end
                    else
                    begin
                        r.field_end = csvt_pkg::FEND_QUOTED;
                        open_token(st, r, it.in_byte);
                    end
                end
                default:
                    open_token(st, r, it.in_byte);
            endcase
        end
        // error step carries the code alone
        if (err != csvt_pkg::ERR_NONE)
        begin
            r = '0;
            r.error_code = err;
            st.halt = err;
        end
        return r;
    endfunction

    // Append one item; the generator keeps its own view of the scan mode
    task automatic queue_item(input logic [7:0] b, input logic eot,
                              input bit typed = 1'b0,
                              input csvt_pkg::out_item_t want = '0);
        text_entry_t e;
        e.item.in_byte = b;
        e.item.end_of_text = eot;
        e.typed = typed;
        e.want = want;
        text_q.push_back(e);
        void'(tokenize_byte(gen_scan, e.item));
    endtask

    // Any byte, leaning toward the three special characters
    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = csvt_pkg::CH_COMMA;
            1:       b = csvt_pkg::CH_NEWLINE;
            2:       b = csvt_pkg::CH_QUOTE;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    // Byte that is plain content outside quotes
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_NEWLINE
               || b == csvt_pkg::CH_QUOTE);
        return b;
    endfunction

    // Well-formed record: fields split by commas, closed by newline or end of text
    task automatic queue_record();
        int unsigned nf;
        int unsigned len;
        int unsigned kind;
        logic [7:0]  b;
        nf = $urandom_range(1, 5);
        for (int unsigned f = 0; f < nf; f++)
        begin
            kind = $urandom_range(0, 9);
            if (kind >= 1 && kind <= 5)
            begin
                len = $urandom_range(1, 8);
                for (int unsigned k = 0; k < len; k++)
                    queue_item(plain_byte(), 1'b0);
            end
            else if (kind >= 6)
            begin
                queue_item(csvt_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 8);
                for (int unsigned k = 0; k < len; k++)
                begin
                    b = any_byte();
                    queue_item(b, 1'b0);
                    if (b == csvt_pkg::CH_QUOTE)
                        queue_item(csvt_pkg::CH_QUOTE, 1'b0);
                end
                queue_item(csvt_pkg::CH_QUOTE, 1'b0);
            end
            if (f + 1 < nf)
                queue_item(csvt_pkg::CH_COMMA, 1'b0);
            else if ($urandom_range(0, 9) == 0)
                queue_item(8'($urandom_range(0, 255)), 1'b1);
            else
                queue_item(csvt_pkg::CH_NEWLINE, 1'b0);
        end
    endtask

    // Loose byte run that never trips an error, then brought back to idle
    task automatic queue_noise();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(1, 12);
        for (int unsigned k = 0; k < n; k++)
        begin
            b = any_byte();
            if ($urandom_range(0, 9) == 0 && gen_scan.mode != csvt_pkg::MODE_QFIELD)
                queue_item(b, 1'b1);
            else if (b == csvt_pkg::CH_QUOTE && gen_scan.mode == csvt_pkg::MODE_FIELD)
                queue_item(csvt_pkg::CH_COMMA, 1'b0);
            else
                queue_item(b, 1'b0);
        end
        if (gen_scan.mode == csvt_pkg::MODE_QFIELD)
            queue_item(csvt_pkg::CH_QUOTE, 1'b0);
        queue_item(csvt_pkg::CH_NEWLINE, 1'b0);
    endtask

    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            failed = 1'b1;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Stimulus build, sender and end of run
    initial
    begin
        int unsigned         calm;
        int unsigned         gap;
        csvt_pkg::out_item_t predicted;
        calm = 0;
        gen_scan = '{mode: csvt_pkg::MODE_IDLE, halt: csvt_pkg::ERR_NONE};
        track_scan = '{mode: csvt_pkg::MODE_IDLE, halt: csvt_pkg::ERR_NONE};

        // Directed table first
        for (int unsigned r = 0; r < DIR_ROWS; r++)
            queue_item(DIRECTED[r].in_byte, DIRECTED[r].eot, DIRECTED[r].typed,
                       DIRECTED[r].want);

        // Random text: mostly records, some loose runs
        while (text_q.size() < TEXT_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
                queue_noise();
            else
                queue_record();
        end

        // One error ends the run (reset is never repeated); then halted items
        if ($urandom_range(0, 1) == 0)
        begin
            queue_item(plain_byte(), 1'b0);
            queue_item(csvt_pkg::CH_QUOTE, 1'b0);
        end
        else
        begin
            queue_item(csvt_pkg::CH_QUOTE, 1'b0);
            queue_item(plain_byte(), 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1);
        end
        for (int unsigned k = 0; k < 8; k++)
            queue_item(any_byte(), k[0]);

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // Sender: valid stays up across back-to-back transfers
        for (int unsigned i = 0; i < text_q.size(); i++)
        begin
            gap = draw_wait(calm);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= text_q[i].item;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predicted = tokenize_byte(track_scan, text_q[i].item);
            expected_tokens.push_back(text_q[i].typed ? text_q[i].want : predicted);
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray results
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, one long hold to back up the input side
    initial
    begin
        int unsigned         calm;
        int unsigned         stall;
        bit                  held_long;
        csvt_pkg::out_item_t want;
        calm = 0;
        held_long = 1'b0;
        tokens_seen = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_long && tokens_seen >= 500)
            begin
                held_long = 1'b1;
                stall = LONG_HOLD;
            end
            else
                stall = draw_wait(calm);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                failed = 1'b1;
                $display("%0t: unexpected result %h", $time, out_data);
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("content_byte", 32'(want.content_byte),
                            32'(out_data.content_byte));
                check_field("content_valid", 32'(want.content_valid),
                            32'(out_data.content_valid));
                check_field("field_start", 32'(want.field_start),
                            32'(out_data.field_start));
                check_field("field_end", 32'(want.field_end),
                            32'(out_data.field_end));
                check_field("delimiter", 32'(want.delimiter),
                            32'(out_data.delimiter));
                check_field("error_code", 32'(want.error_code),
                            32'(out_data.error_code));
            end
        end
    end

endmodule

// ===== files.f =====
src/csvt_pkg.sv
src/csv_byte_tokenizer_unit.sv
tb/sv/testbench.sv
